// File: rtl/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker: character
// codes, the character class decoded from a text byte and the step command
// that drives the checker state.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned BRACKET_DEPTH_DEF = 64;
  localparam int unsigned PAREN_DEPTH_DEF   = 64;

  localparam logic [7:0] CH_NEWLINE      = 8'h0A;
  localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CH_BRACE_OPEN   = 8'h7B;
  localparam logic [7:0] CH_BRACE_CLOSE  = 8'h7D;

  // Stack entry kinds.
  localparam logic KIND_SQUARE = 1'b1;
  localparam logic KIND_BRACE  = 1'b0;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NEWLINE,
    CLS_PAREN_OPEN,
    CLS_PAREN_CLOSE,
    CLS_SQUARE_OPEN,
    CLS_SQUARE_CLOSE,
    CLS_BRACE_OPEN,
    CLS_BRACE_CLOSE
  } char_class_e;

  // One state update: en marks a transfer leaving the input register,
  // eos marks the end of the text.
  typedef struct packed {
    logic        en;
    logic        eos;
    char_class_e cls;
  } step_t;

endpackage : bbc_pkg
`default_nettype wire

// File: rtl/bbc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_in_if / bbc_out_if
// Valid/ready channels of the bracket balance checker: text items in,
// verdicts out.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] text_byte;

  modport source (output valid, output action, output text_byte, input ready);
  modport sink   (input valid, input action, input text_byte, output ready);
endinterface : bbc_in_if

interface bbc_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface : bbc_out_if
`default_nettype wire

// File: rtl/bbc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_decode
// Maps a text byte onto its character class.
// ----------------------------------------------------------------------------
module bbc_decode (
  input  logic [7:0]           text_byte_i,
  output bbc_pkg::char_class_e cls_o
);
  import bbc_pkg::*;

  always_comb begin
    unique case (text_byte_i)
      CH_NEWLINE:      cls_o = CLS_NEWLINE;
      CH_PAREN_OPEN:   cls_o = CLS_PAREN_OPEN;
      CH_PAREN_CLOSE:  cls_o = CLS_PAREN_CLOSE;
      CH_SQUARE_OPEN:  cls_o = CLS_SQUARE_OPEN;
      CH_SQUARE_CLOSE: cls_o = CLS_SQUARE_CLOSE;
      CH_BRACE_OPEN:   cls_o = CLS_BRACE_OPEN;
      CH_BRACE_CLOSE:  cls_o = CLS_BRACE_CLOSE;
      default:         cls_o = CLS_OTHER;
    endcase
  end

endmodule : bbc_decode
`default_nettype wire

// File: rtl/bbc_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_state
// Checker state: open parenthesis count, kind stack of square brackets and
// braces held as a shift line, first-line flag and sticky error.
// ----------------------------------------------------------------------------
module bbc_state #(
  parameter int unsigned BracketDepth = bbc_pkg::BRACKET_DEPTH_DEF,
  parameter int unsigned ParenDepth   = bbc_pkg::PAREN_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbc_pkg::step_t step_i,
  output logic           verdict_o
);
  import bbc_pkg::*;

  localparam int unsigned PW = $clog2(ParenDepth + 1);
  localparam int unsigned BW = $clog2(BracketDepth + 1);

  logic [PW-1:0]           paren_q, paren_d;
  logic [BW-1:0]           depth_q, depth_d;
  logic                    first_q, first_d;
  logic                    err_q, err_d;
  logic [BracketDepth-1:0] stack_q, stack_push, stack_pop;
  logic                    push, pop, kind;
  logic                    paren_full, stack_full, stack_match;

  assign paren_full = (paren_q == PW'(ParenDepth));
  assign stack_full = (depth_q == BW'(BracketDepth));

  // The top of the stack is always entry 0.
  assign kind = (step_i.cls == CLS_SQUARE_OPEN || step_i.cls == CLS_SQUARE_CLOSE) ?
                KIND_SQUARE : KIND_BRACE;
  assign stack_match = !first_q && (depth_q != '0) && (stack_q[0] == kind);

  for (genvar i = 0; i < BracketDepth; i++) begin : g_stack
    if (i == 0) begin : g_top
      assign stack_push[i] = kind;
    end else begin : g_below
      assign stack_push[i] = stack_q[i-1];
    end
    if (i == BracketDepth - 1) begin : g_bottom
      assign stack_pop[i] = stack_q[i];
    end else begin : g_above
      assign stack_pop[i] = stack_q[i+1];
    end
  end

  always_comb begin
    paren_d = paren_q;
    depth_d = depth_q;
    first_d = first_q;
    err_d   = err_q;
    push    = 1'b0;
    pop     = 1'b0;
    if (step_i.en && step_i.eos) begin
      paren_d = '0;
      depth_d = '0;
      first_d = 1'b1;
      err_d   = 1'b0;
    end else if (step_i.en) begin
      unique case (step_i.cls)
        CLS_NEWLINE: begin
          if (paren_q != '0) err_d = 1'b1;
          paren_d = '0;
          first_d = 1'b0;
        end
        CLS_PAREN_OPEN: begin
          if (paren_full) err_d = 1'b1;
          else paren_d = paren_q + PW'(1);
        end
        CLS_PAREN_CLOSE: begin
          if (paren_q == '0) err_d = 1'b1;
          else paren_d = paren_q - PW'(1);
        end
        CLS_SQUARE_OPEN, CLS_BRACE_OPEN: begin
          if (stack_full) begin
            err_d = 1'b1;
          end else begin
            push    = 1'b1;
            depth_d = depth_q + BW'(1);
          end
        end
        CLS_SQUARE_CLOSE, CLS_BRACE_CLOSE: begin
          if (!stack_match) begin
            err_d = 1'b1;
          end else begin
            pop     = 1'b1;
            depth_d = depth_q - BW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign verdict_o = !err_q && (paren_q == '0) && (depth_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paren_q <= '0;
      depth_q <= '0;
      first_q <= 1'b1;
      err_q   <= 1'b0;
    end else begin
      paren_q <= paren_d;
      depth_q <= depth_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q <= stack_push;
    end else if (pop) begin
      stack_q <= stack_pop;
    end
  end

endmodule : bbc_state
`default_nettype wire

// File: rtl/bracket_balance_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks the brackets of a byte stream and gives a verdict at end of text.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload              | Transfer
//  --------+-----------+----------------------+-------------------------------
//  in_i    | in        | action, text_byte    | one text byte or end of text
//  out_o   | out       | valid_res            | one verdict per end of text
//
// Cycles: one item is taken every cycle unless an end-of-text item waits in the
// input register, where each item is decoded and applied to the checker state;
// an end-of-text verdict reaches the output register in the cycle after it leaves.
// Stalls: text bytes never wait on the output side. An end-of-text item waits
// in the input register only while an earlier verdict is still held in the
// output register and out_o.ready is low.
// Reset: rst_ni clears all control state at once; the kind stack needs no
// clearing since only entries below the current depth are ever read.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int unsigned BracketDepth = bbc_pkg::BRACKET_DEPTH_DEF,
  parameter int unsigned ParenDepth   = bbc_pkg::PAREN_DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bbc_in_if.sink     in_i,
  bbc_out_if.source  out_o
);
  import bbc_pkg::*;

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic       s1_action_q;
  logic [7:0] s1_byte_q;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic valid_res_q;

  logic        in_xfer;
  logic        s1_adv;
  logic        verdict;
  char_class_e cls;
  step_t       step;

  // A text byte always leaves the input register; an end-of-text item needs
  // the output register to be free or emptying in this cycle.
  assign s1_adv  = s1_valid_q && (!s1_action_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !s1_adv);
  assign out_valid_d = (s1_adv && s1_action_q) || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= in_i.action;
      s1_byte_q   <= in_i.text_byte;
    end
    if (s1_adv && s1_action_q) begin
      valid_res_q <= verdict;
    end
  end

  bbc_decode u_decode (
    .text_byte_i (s1_byte_q),
    .cls_o       (cls)
  );

  assign step.en  = s1_adv;
  assign step.eos = s1_action_q;
  assign step.cls = cls;

  // The verdict is read from the state before the end-of-text item clears it.
  bbc_state #(
    .BracketDepth (BracketDepth),
    .ParenDepth   (ParenDepth)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .verdict_o (verdict)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = valid_res_q;

  // An end-of-text item that leaves the input register always shows a verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_action_q) |=> out_valid_q)
    else $error("verdict was not presented after end of text");

  // A pending verdict is never overwritten before its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && s1_action_q && out_valid_q && !out_o.ready))
    else $error("pending verdict overwritten");

  // An item held in the input register keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_action_q)
                                 && $stable(s1_byte_q)))
    else $error("held item in input register changed");

endmodule : bracket_balance_checker
`default_nettype wire
